FILE: src/tmodf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmodf_pkg
// Types, constants and pair decode shared by the direction finder modules.
// ----------------------------------------------------------------------------
package tmodf_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam logic [22:0] QUARTER_TURN = 23'd4194304;
    localparam logic [23:0] HALF_TURN    = 24'd8388608;
    localparam logic [15:0] ANGLE_SCALE  = 16'd46080;
    localparam logic [8:0]  SOUND_K      = 9'd343;

    localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669,
        22'd83416, 22'd41718, 22'd20860, 22'd10430, 22'd5215,
        22'd2608, 22'd1304, 22'd652, 22'd326, 22'd163,
        22'd81, 22'd41, 22'd20, 22'd10, 22'd5
    };

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_DIST_12   = 3'd1,
        REG_DIST_13   = 3'd2,
        REG_DIST_23   = 3'd3,
        REG_BEARING_12 = 3'd4,
        REG_BEARING_13 = 3'd5,
        REG_BEARING_23 = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        PAIR_12 = 2'd0,
        PAIR_13 = 2'd1,
        PAIR_23 = 2'd2
    } t_pair;

    typedef struct packed {
        logic [15:0] dist_12;
        logic [15:0] dist_13;
        logic [15:0] dist_23;
        logic [15:0] bearing_12;
        logic [15:0] bearing_13;
        logic [15:0] bearing_23;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  first;
        logic [1:0]  second;
        logic [15:0] lag;
    } t_job;

    typedef struct packed {
        logic        status;
        logic [15:0] angle;
        logic [1:0]  first;
        logic [1:0]  second;
        logic [15:0] lag;
    } t_res;

    typedef struct packed {
        logic  ok;
        t_pair pair;
        logic  right;
        logic  rev;
    } t_decode;

    typedef enum logic [3:0] {
        B_IDLE, B_MUL, B_DIV, B_SQR, B_ROOT, B_CORD, B_ANG, B_SCALE, B_DONE
    } t_bstate;

    function automatic t_decode decode_order(input logic [1:0] first,
                                             input logic [1:0] second);
        t_decode d;
        d = '{ok: 1'b1, pair: PAIR_12, right: 1'b0, rev: 1'b0};
        unique case ({first, second})
            4'd6:  d = '{ok: 1'b1, pair: PAIR_12, right: 1'b0, rev: 1'b0};
            4'd7:  d = '{ok: 1'b1, pair: PAIR_13, right: 1'b1, rev: 1'b0};
            4'd9:  d = '{ok: 1'b1, pair: PAIR_12, right: 1'b1, rev: 1'b1};
            4'd11: d = '{ok: 1'b1, pair: PAIR_23, right: 1'b0, rev: 1'b0};
            4'd13: d = '{ok: 1'b1, pair: PAIR_13, right: 1'b0, rev: 1'b1};
            4'd14: d = '{ok: 1'b1, pair: PAIR_23, right: 1'b1, rev: 1'b1};
            default: d.ok = 1'b0;
        endcase
        return d;
    endfunction

endpackage

FILE: src/three_mic_onset_direction_finder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_mic_onset_direction_finder_core
// Three-microphone onset order, lag and direction of arrival.
// ----------------------------------------------------------------------------
// Samples are taken in one per cycle while full is low; the onset tracker
// handles each sample as it arrives. Each frame gives at most one result, which
// the solver works out with a 30-step restoring divide, a 32-step square root
// and a 20-step CORDIC, all on one shared sequential datapath.
// A two-entry job queue sits between tracker and solver, and one output
// register holds the finished result until it is popped.
module three_mic_onset_direction_finder_core #(
    parameter int LAG_MAX     = 65535,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_sample_mic1,
    input  logic [15:0] i_sample_mic2,
    input  logic [15:0] i_sample_mic3,
    input  logic        i_frame_end,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_status,
    output logic [15:0] o_direction_angle,
    output logic [1:0]  o_first_mic,
    output logic [1:0]  o_second_mic,
    output logic [15:0] o_lag_count
);

    logic [15:0]     r_threshold;
    tmodf_pkg::t_cfg r_cfg;
    tmodf_pkg::t_job f_job, q_job;
    tmodf_pkg::t_res res;
    logic            q_push, q_full, q_empty, q_pop, accept;
    tmodf_pkg::t_reg_idx idx;

    assign pready = 1'b1;
    assign idx    = tmodf_pkg::t_reg_idx'(paddr[4:2]);
    assign full   = q_full;
    assign accept = push && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold      <= 16'd16384;
            r_cfg.dist_12    <= 16'd1600;
            r_cfg.dist_13    <= 16'd1600;
            r_cfg.dist_23    <= 16'd1600;
            r_cfg.bearing_12 <= 16'd0;
            r_cfg.bearing_13 <= 16'd10923;
            r_cfg.bearing_23 <= 16'd21845;
        end else if (psel && penable && pwrite) begin
            case (idx)
                tmodf_pkg::REG_THRESHOLD:  r_threshold      <= pwdata[15:0];
                tmodf_pkg::REG_DIST_12:    r_cfg.dist_12    <= pwdata[15:0];
                tmodf_pkg::REG_DIST_13:    r_cfg.dist_13    <= pwdata[15:0];
                tmodf_pkg::REG_DIST_23:    r_cfg.dist_23    <= pwdata[15:0];
                tmodf_pkg::REG_BEARING_12: r_cfg.bearing_12 <= pwdata[15:0];
                tmodf_pkg::REG_BEARING_13: r_cfg.bearing_13 <= pwdata[15:0];
                tmodf_pkg::REG_BEARING_23: r_cfg.bearing_23 <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            tmodf_pkg::REG_THRESHOLD:  prdata = {16'd0, r_threshold};
            tmodf_pkg::REG_DIST_12:    prdata = {16'd0, r_cfg.dist_12};
            tmodf_pkg::REG_DIST_13:    prdata = {16'd0, r_cfg.dist_13};
            tmodf_pkg::REG_DIST_23:    prdata = {16'd0, r_cfg.dist_23};
            tmodf_pkg::REG_BEARING_12: prdata = {16'd0, r_cfg.bearing_12};
            tmodf_pkg::REG_BEARING_13: prdata = {16'd0, r_cfg.bearing_13};
            tmodf_pkg::REG_BEARING_23: prdata = {16'd0, r_cfg.bearing_23};
            default:                   prdata = 32'd0;
        endcase
    end

    tmodf_front #(
        .LAG_MAX     (LAG_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_threshold   (r_threshold),
        .i_sample_mic1 (i_sample_mic1),
        .i_sample_mic2 (i_sample_mic2),
        .i_sample_mic3 (i_sample_mic3),
        .i_frame_end   (i_frame_end),
        .i_accept      (accept),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_job         (f_job)
    );

    tmodf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    tmodf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (!q_empty),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_result_status   = res.status;
    assign o_direction_angle = res.angle;
    assign o_first_mic       = res.first;
    assign o_second_mic      = res.second;
    assign o_lag_count       = res.lag;

`ifndef SYNTH
    a_fail_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_status) |-> (o_direction_angle == 16'd0))
        else $error("failed result carries an angle");

    a_valid_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result_status) |->
            (o_first_mic != 2'd0 && o_second_mic != 2'd0 && o_first_mic != o_second_mic))
        else $error("valid result without a resolved pair");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");
`endif

endmodule

FILE: src/tmodf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmodf_front
// Onset tracker: accepts samples, records trigger order and lag, queues jobs.
// ----------------------------------------------------------------------------
module tmodf_front #(
    parameter int LAG_MAX     = 65535,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [15:0]           i_threshold,
    input  logic [15:0]           i_sample_mic1,
    input  logic [15:0]           i_sample_mic2,
    input  logic [15:0]           i_sample_mic3,
    input  logic                  i_frame_end,
    input  logic                  i_accept,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output tmodf_pkg::t_job       o_job
);

    logic [2:0]         r_trig, n_trig;
    logic [1:0]         r_first, n_first;
    logic [1:0]         r_second, n_second;
    logic signed [16:0] r_lag, n_lag;
    logic               r_done;
    logic               third;
    logic [2:0]         ge;
    logic [SAMPLE_BITS-1:0] thr;
    logic [SAMPLE_BITS-1:0] smp [3];

    assign thr    = SAMPLE_BITS'(i_threshold);
    assign smp[0] = SAMPLE_BITS'(i_sample_mic1);
    assign smp[1] = SAMPLE_BITS'(i_sample_mic2);
    assign smp[2] = SAMPLE_BITS'(i_sample_mic3);

    always_comb begin
        for (int m = 0; m < 3; m++) begin
            ge[m] = $signed(smp[m]) >= $signed(thr);
        end
    end

    always_comb begin
        n_trig   = r_trig;
        n_first  = r_first;
        n_second = r_second;
        n_lag    = r_lag;
        third    = 1'b0;
        for (int m = 0; m < 3; m++) begin
            if (!n_trig[m] && ge[m]) begin
                n_trig[m] = 1'b1;
                if (n_first == 2'd0) begin
                    n_first = 2'(m + 1);
                end else if (n_second == 2'd0) begin
                    n_second = 2'(m + 1);
                end else begin
                    third = 1'b1;
                end
            end
        end
        if (n_first != 2'd0 && n_second == 2'd0 && n_lag < $signed(17'(LAG_MAX))) begin
            n_lag = n_lag + 17'sd1;
        end
        if (n_second != 2'd0 && n_lag < 17'sd0) begin
            n_lag = 17'sd0;
        end
    end

    assign o_q_push     = i_accept && !r_done && (third || i_frame_end) && !i_q_full;
    assign o_job.first  = n_first;
    assign o_job.second = n_second;
    assign o_job.lag    = n_lag[16] ? 16'd0 : n_lag[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig   <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_lag    <= -17'sd1;
            r_done   <= 1'b0;
        end else if (i_accept) begin
            if (i_frame_end) begin
                r_trig   <= '0;
                r_first  <= '0;
                r_second <= '0;
                r_lag    <= -17'sd1;
                r_done   <= 1'b0;
            end else if (!r_done) begin
                r_trig   <= n_trig;
                r_first  <= n_first;
                r_second <= n_second;
                r_lag    <= n_lag;
                r_done   <= third;
            end
        end
    end

endmodule

FILE: src/tmodf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmodf_queue
// Two-entry job queue between the onset tracker and the direction solver.
// ----------------------------------------------------------------------------
module tmodf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tmodf_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output tmodf_pkg::t_job o_job
);

    tmodf_pkg::t_job r_mem [2];
    logic            r_wr, r_rd;
    logic [1:0]      r_cnt;
    logic            do_push, do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

FILE: src/tmodf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmodf_back
// Direction solver: divide, square root, CORDIC arcsine, angle scaling.
// ----------------------------------------------------------------------------
module tmodf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tmodf_pkg::t_cfg i_cfg,
    input  logic            i_job_valid,
    input  tmodf_pkg::t_job i_job,
    output logic            o_job_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output tmodf_pkg::t_res o_res
);

    tmodf_pkg::t_bstate r_state, n_state;
    tmodf_pkg::t_job    r_job;
    tmodf_pkg::t_decode r_dec;
    tmodf_pkg::t_res    r_out;
    logic               r_out_valid;
    logic [24:0]        r_prod;
    logic [16:0]        r_rem;
    logic [30:0]        r_r;
    logic [60:0]        r_v;
    logic [62:0]        r_res;
    logic [62:0]        r_bit;
    logic signed [33:0] r_x, r_y;
    logic signed [25:0] r_z;
    logic [4:0]         r_cnt;
    logic [39:0]        r_scaled;
    logic [15:0]        r_angle;
    logic               r_status;

    logic [15:0] pair_dist, base;
    logic [16:0] rem2;
    logic [62:0] trial;
    logic [22:0] zc;
    logic [23:0] b, t, a;
    logic        load_out, last;
    logic signed [33:0] cx;

    always_comb begin
        unique case (r_dec.pair)
            tmodf_pkg::PAIR_12: begin pair_dist = i_cfg.dist_12; base = i_cfg.bearing_12; end
            tmodf_pkg::PAIR_13: begin pair_dist = i_cfg.dist_13; base = i_cfg.bearing_13; end
            tmodf_pkg::PAIR_23: begin pair_dist = i_cfg.dist_23; base = i_cfg.bearing_23; end
            default:            begin pair_dist = i_cfg.dist_23; base = i_cfg.bearing_23; end
        endcase
    end

    assign rem2  = {r_rem[15:0], 1'b0};
    assign trial = r_res + r_bit;
    assign zc    = r_z[25] ? 23'd0 :
                   (r_z > 26'(tmodf_pkg::QUARTER_TURN)) ? tmodf_pkg::QUARTER_TURN : r_z[22:0];
    assign b     = {base, 8'd0} + (r_dec.rev ? tmodf_pkg::HALF_TURN : 24'd0);
    assign t     = 24'(zc) + 24'(tmodf_pkg::QUARTER_TURN);
    assign a     = r_dec.right ? b + t : b - t;
    assign load_out = !r_out_valid || i_pop;
    assign last  = r_cnt == 5'(tmodf_pkg::CORDIC_STEPS - 1);
    assign cx    = (r_cnt == 5'd0) ? $signed(34'(r_res)) : r_x;

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        unique case (r_state)
            tmodf_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state   = tmodf_pkg::B_MUL;
                end
            end
            tmodf_pkg::B_MUL: begin
                if (!r_dec.ok) begin
                    n_state = tmodf_pkg::B_DONE;
                end else if (r_prod >= 25'(pair_dist)) begin
                    n_state = tmodf_pkg::B_SQR;
                end else begin
                    n_state = tmodf_pkg::B_DIV;
                end
            end
            tmodf_pkg::B_DIV:   if (r_cnt == 5'd29) n_state = tmodf_pkg::B_SQR;
            tmodf_pkg::B_SQR:   n_state = tmodf_pkg::B_ROOT;
            tmodf_pkg::B_ROOT:  if (r_bit == 63'd1) n_state = tmodf_pkg::B_CORD;
            tmodf_pkg::B_CORD:  if (last) n_state = tmodf_pkg::B_ANG;
            tmodf_pkg::B_ANG:   n_state = tmodf_pkg::B_SCALE;
            tmodf_pkg::B_SCALE: n_state = tmodf_pkg::B_DONE;
            tmodf_pkg::B_DONE:  if (load_out) n_state = tmodf_pkg::B_IDLE;
            default:            n_state = tmodf_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmodf_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tmodf_pkg::B_IDLE: begin
                r_job    <= i_job;
                r_dec    <= tmodf_pkg::decode_order(i_job.first, i_job.second);
                r_prod   <= 25'(tmodf_pkg::SOUND_K) * 25'(i_job.lag);
                r_status <= 1'b1;
                r_angle  <= '0;
            end
            tmodf_pkg::B_MUL: begin
                r_rem <= r_prod[16:0];
                r_cnt <= '0;
                r_r   <= 31'd1 << 30;
            end
            tmodf_pkg::B_DIV: begin
                if (rem2 >= 17'(pair_dist)) begin
                    r_rem <= rem2 - 17'(pair_dist);
                    r_r   <= {r_r[29:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_r   <= {r_r[29:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
            end
            tmodf_pkg::B_SQR: begin
                r_v   <= (61'd1 << 60) - 61'(62'(r_r) * 62'(r_r));
                r_res <= '0;
                r_bit <= 63'd1 << 62;
            end
            tmodf_pkg::B_ROOT: begin
                if (63'(r_v) >= trial) begin
                    r_v   <= 61'(63'(r_v) - trial);
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_x   <= 34'(r_res);
                r_y   <= 34'(r_r);
                r_z   <= '0;
                r_cnt <= '0;
            end
            tmodf_pkg::B_CORD: begin
                if (!r_y[33]) begin
                    r_x <= cx + (r_y >>> r_cnt);
                    r_y <= r_y - (cx >>> r_cnt);
                    r_z <= r_z + 26'(tmodf_pkg::ATAN_TAB[r_cnt]);
                end else begin
                    r_x <= cx - (r_y >>> r_cnt);
                    r_y <= r_y + (cx >>> r_cnt);
                    r_z <= r_z - 26'(tmodf_pkg::ATAN_TAB[r_cnt]);
                end
                r_cnt <= r_cnt + 5'd1;
            end
            tmodf_pkg::B_ANG: begin
                r_scaled <= 40'(a) * 40'(tmodf_pkg::ANGLE_SCALE);
            end
            tmodf_pkg::B_SCALE: begin
                r_status <= 1'b0;
                r_angle  <= 16'((r_scaled + 40'(tmodf_pkg::HALF_TURN)) >> 24);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tmodf_pkg::B_DONE && load_out) begin
            r_out.status <= r_status;
            r_out.angle  <= r_angle;
            r_out.first  <= r_job.first;
            r_out.second <= r_job.second;
            r_out.lag    <= r_job.lag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == tmodf_pkg::B_DONE && load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_res   = r_out;

endmodule
